// File: design/apc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box pair collision package
// Shared types and widths for the controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package apc_pkg;

    localparam int CoordW  = 16;   // signed Q12.4 coordinates
    localparam int SizeW   = 15;   // unsigned Q11.4 sizes
    localparam int EdgeW   = 18;   // signed width of an edge sum
    localparam int IdxOutW = 3;    // index width on the result stream
    localparam int PenW    = 15;   // penetration depth width

    typedef struct packed {
        logic                     is_static;
        logic        [SizeW-1:0]  height;
        logic        [SizeW-1:0]  width;
        logic signed [CoordW-1:0] top;
        logic signed [CoordW-1:0] left;
    } t_box;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic store_we;    // write the incoming box into the store
        logic edge_en;     // register edge sums of the selected pair
        logic pen_en;      // register overlap and penetration per axis
        logic emit_pair;   // load a pair result into the output register
        logic emit_end;    // load the end-of-frame result
        logic ovf;         // overflow flag for the end-of-frame result
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic slot_free;   // output register can take a result this cycle
        logic hit;         // registered pair overlaps and is not static-static
    } t_dp_status;

endpackage

// File: design/apc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box pair collision datapath
// Box store, pair test pipeline and the output register.
// ----------------------------------------------------------------------------
module apc_datapath
    import apc_pkg::*;
#(
    parameter int MAX_BOXES = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  t_box                                   i_box,
    input  logic [$clog2(MAX_BOXES)-1:0]           i_wr_addr,
    input  logic [$clog2(MAX_BOXES)-1:0]           i_rd_a,
    input  logic [$clog2(MAX_BOXES)-1:0]           i_rd_b,
    input  t_dp_cmd                                i_cmd,
    output t_dp_status                             o_status,
    input  logic                                   i_m_tready,
    output logic                                   o_m_tvalid,
    output logic [IdxOutW-1:0]                     o_first_index,
    output logic [IdxOutW-1:0]                     o_second_index,
    output logic [PenW-1:0]                        o_penetration,
    output logic                                   o_normal_on_y,
    output logic                                   o_normal_negative,
    output logic                                   o_frame_done,
    output logic                                   o_overflowed
);

    localparam int IW = $clog2(MAX_BOXES);

    t_box r_mem [MAX_BOXES];
    t_box r_p;
    t_box r_q;

    // Edge stage
    logic signed [EdgeW-1:0] r_pl, r_pr, r_pt, r_pb;
    logic signed [EdgeW-1:0] r_ql, r_qr, r_qt, r_qb;
    logic                    r_both_static;

    // Penetration stage
    logic            r_hit;
    logic [PenW-1:0] r_penx, r_peny;
    logic            r_negx, r_negy;

    // Output register
    logic               r_out_valid;
    logic [IdxOutW-1:0] r_first, r_second;
    logic [PenW-1:0]    r_pen;
    logic               r_ny, r_neg, r_done, r_ovf;

    logic signed [EdgeW-1:0] pl_ext, pt_ext, ql_ext, qt_ext;
    logic signed [EdgeW-1:0] pw_ext, ph_ext, qw_ext, qh_ext;
    logic                    overlap, negx, negy;
    logic signed [EdgeW-1:0] penx_full, peny_full;
    logic                    x_smaller;
    logic [IW+IdxOutW-1:0]   idx_a_ext, idx_b_ext;
    logic                    slot_free;

    always_ff @(posedge i_clk) begin
        if (i_cmd.store_we) begin
            r_mem[i_wr_addr] <= i_box;
        end
        r_p <= r_mem[i_rd_a];
        r_q <= r_mem[i_rd_b];
    end

    always_comb begin
        pl_ext = EdgeW'(r_p.left);
        pt_ext = EdgeW'(r_p.top);
        ql_ext = EdgeW'(r_q.left);
        qt_ext = EdgeW'(r_q.top);
        pw_ext = $signed({{(EdgeW-SizeW){1'b0}}, r_p.width});
        ph_ext = $signed({{(EdgeW-SizeW){1'b0}}, r_p.height});
        qw_ext = $signed({{(EdgeW-SizeW){1'b0}}, r_q.width});
        qh_ext = $signed({{(EdgeW-SizeW){1'b0}}, r_q.height});
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.edge_en) begin
            r_pl          <= pl_ext;
            r_pt          <= pt_ext;
            r_ql          <= ql_ext;
            r_qt          <= qt_ext;
            r_pr          <= pl_ext + pw_ext;
            r_pb          <= pt_ext + ph_ext;
            r_qr          <= ql_ext + qw_ext;
            r_qb          <= qt_ext + qh_ext;
            r_both_static <= r_p.is_static & r_q.is_static;
        end
    end

    // Touching edges count as overlap, hence the strict compares.
    always_comb begin
        overlap   = !((r_pr < r_ql) || (r_pl > r_qr) || (r_pb < r_qt) || (r_pt > r_qb));
        negx      = r_pl < r_ql;
        negy      = r_pt < r_qt;
        penx_full = negx ? (r_pr - r_ql) : (r_qr - r_pl);
        peny_full = negy ? (r_pb - r_qt) : (r_qb - r_pt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_cmd.pen_en) begin
            r_hit <= overlap & ~r_both_static;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pen_en) begin
            r_penx <= penx_full[PenW-1:0];
            r_peny <= peny_full[PenW-1:0];
            r_negx <= negx;
            r_negy <= negy;
        end
    end

    // A tie between the axes picks Y.
    always_comb begin
        x_smaller = r_penx < r_peny;
        idx_a_ext = {{IdxOutW{1'b0}}, i_rd_a};
        idx_b_ext = {{IdxOutW{1'b0}}, i_rd_b};
        slot_free = ~r_out_valid | i_m_tready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_pair || i_cmd.emit_end) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_pair) begin
            r_first  <= idx_a_ext[IdxOutW-1:0];
            r_second <= idx_b_ext[IdxOutW-1:0];
            r_pen    <= x_smaller ? r_penx : r_peny;
            r_ny     <= ~x_smaller;
            r_neg    <= x_smaller ? r_negx : r_negy;
            r_done   <= 1'b0;
            r_ovf    <= 1'b0;
        end else if (i_cmd.emit_end) begin
            r_first  <= '0;
            r_second <= '0;
            r_pen    <= '0;
            r_ny     <= 1'b0;
            r_neg    <= 1'b0;
            r_done   <= 1'b1;
            r_ovf    <= i_cmd.ovf;
        end
    end

    assign o_status.slot_free = slot_free;
    assign o_status.hit       = r_hit;
    assign o_m_tvalid         = r_out_valid;
    assign o_first_index      = r_first;
    assign o_second_index     = r_second;
    assign o_penetration      = r_pen;
    assign o_normal_on_y      = r_ny;
    assign o_normal_negative  = r_neg;
    assign o_frame_done       = r_done;
    assign o_overflowed       = r_ovf;

endmodule

// File: design/apc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box pair collision controller
// Counts loaded boxes and walks the pair indices through the test pipeline.
// ----------------------------------------------------------------------------
module apc_ctrl
    import apc_pkg::*;
#(
    parameter int MAX_BOXES = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tlast,
    output logic                          o_s_tready,
    input  t_dp_status                    i_status,
    output t_dp_cmd                       o_cmd,
    output logic [$clog2(MAX_BOXES)-1:0]  o_wr_addr,
    output logic [$clog2(MAX_BOXES)-1:0]  o_rd_a,
    output logic [$clog2(MAX_BOXES)-1:0]  o_rd_b
);

    localparam int IW = $clog2(MAX_BOXES);
    localparam int CW = $clog2(MAX_BOXES + 1);
    localparam logic [CW-1:0] MaxCount = CW'(MAX_BOXES);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_READ,
        ST_EDGE,
        ST_PEN,
        ST_EMIT,
        ST_END
    } t_state;

    t_state        r_state;
    logic [CW-1:0] r_count;
    logic          r_ovf;
    logic [IW-1:0] r_i, r_j;

    logic          accept, room;
    logic [CW-1:0] count_after;
    logic          last_j, last_i, advance;
    logic [IW:0]   i_plus1, i_plus2, j_plus1;

    always_comb begin
        accept      = (r_state == ST_LOAD) & i_s_tvalid;
        room        = r_count < MaxCount;
        count_after = room ? (r_count + CW'(1)) : r_count;
        last_j      = CW'(r_j) == (r_count - CW'(1));
        last_i      = CW'(r_i) == (r_count - CW'(2));
        i_plus1     = {1'b0, r_i} + (IW+1)'(1);
        i_plus2     = {1'b0, r_i} + (IW+1)'(2);
        j_plus1     = {1'b0, r_j} + (IW+1)'(1);
        advance     = (r_state == ST_EMIT) & (~i_status.hit | i_status.slot_free);

        o_cmd.store_we  = accept & room;
        o_cmd.edge_en   = r_state == ST_EDGE;
        o_cmd.pen_en    = r_state == ST_PEN;
        o_cmd.emit_pair = (r_state == ST_EMIT) & i_status.hit & i_status.slot_free;
        o_cmd.emit_end  = (r_state == ST_END) & i_status.slot_free;
        o_cmd.ovf       = r_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            unique case (r_state)
                ST_LOAD: begin
                    if (accept) begin
                        r_count <= count_after;
                        if (!room) begin
                            r_ovf <= 1'b1;
                        end
                        if (i_s_tlast) begin
                            r_i <= '0;
                            r_j <= IW'(1);
                            r_state <= (count_after >= CW'(2)) ? ST_READ : ST_END;
                        end
                    end
                end
                ST_READ: r_state <= ST_EDGE;
                ST_EDGE: r_state <= ST_PEN;
                ST_PEN:  r_state <= ST_EMIT;
                ST_EMIT: begin
                    if (advance) begin
                        if (last_j) begin
                            if (last_i) begin
                                r_state <= ST_END;
                            end else begin
                                r_i     <= i_plus1[IW-1:0];
                                r_j     <= i_plus2[IW-1:0];
                                r_state <= ST_READ;
                            end
                        end else begin
                            r_j     <= j_plus1[IW-1:0];
                            r_state <= ST_READ;
                        end
                    end
                end
                ST_END: begin
                    if (i_status.slot_free) begin
                        r_count <= '0;
                        r_ovf   <= 1'b0;
                        r_state <= ST_LOAD;
                    end
                end
                default: r_state <= ST_LOAD;
            endcase
        end
    end

    assign o_s_tready = r_state == ST_LOAD;
    assign o_wr_addr  = r_count[IW-1:0];
    assign o_rd_a     = r_i;
    assign o_rd_b     = r_j;

endmodule

// File: design/aabb_pairwise_collision.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Axis-aligned box pair collision detector
// Loads a frame of boxes and streams one result per overlapping pair.
// ----------------------------------------------------------------------------
// Usage: each slave-side transaction carries one box. The transaction with
// tlast high closes the frame and starts the pair tests; the slave side is
// not ready again until the frame has been fully reported. Boxes beyond
// MAX_BOXES are dropped, which is flagged on the end-of-frame result.
// Every pair i<j is tested in load order; pairs of two static boxes are
// not reported. Each overlapping pair yields one master-side transaction with the
// indices, the depth on the shallower axis (ties take Y) and the normal sign;
// a final transaction with tlast high and tuser holding the overflow flag
// ends the frame.
// Boxes are taken back to back while loading. Each pair passes through
// store read, edge sums, penetration and result load in the controller's
// walk; any time spent with the output stalled adds to a frame's run.
// The result register holds one transaction; while the receiver keeps tready
// low the pair walk halts at the next overlapping pair until the slot frees.
// Reset empties the frame and the result register; the store is not cleared.
// ----------------------------------------------------------------------------
module aabb_pairwise_collision
    import apc_pkg::*;
#(
    parameter int MAX_BOXES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // box_left[15:0], box_top[31:16], box_width[46:32], box_height[61:47], zero
    input  logic [63:0] i_s_tdata,
    // is_static
    input  logic        i_s_tuser,
    // frame_last
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // first_index[2:0], second_index[5:3], penetration[20:6],
    // normal_on_y[21], normal_negative[22], zero[23]
    output logic [23:0] o_m_tdata,
    // overflowed
    output logic        o_m_tuser,
    // frame_done
    output logic        o_m_tlast
);

    localparam int IW = $clog2(MAX_BOXES);

    t_box          box_in;
    t_dp_cmd       cmd;
    t_dp_status    status;
    logic [IW-1:0] wr_addr, rd_a, rd_b;

    logic [IdxOutW-1:0] first_index, second_index;
    logic [PenW-1:0]    penetration;
    logic               normal_on_y, normal_negative;

    // Unpack the incoming box.
    always_comb begin
        box_in.left      = i_s_tdata[15:0];
        box_in.top       = i_s_tdata[31:16];
        box_in.width     = i_s_tdata[46:32];
        box_in.height    = i_s_tdata[61:47];
        box_in.is_static = i_s_tuser;
    end

    apc_ctrl #(
        .MAX_BOXES (MAX_BOXES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tlast  (i_s_tlast),
        .o_s_tready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_wr_addr  (wr_addr),
        .o_rd_a     (rd_a),
        .o_rd_b     (rd_b)
    );

    apc_datapath #(
        .MAX_BOXES (MAX_BOXES)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_box             (box_in),
        .i_wr_addr         (wr_addr),
        .i_rd_a            (rd_a),
        .i_rd_b            (rd_b),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_m_tready        (i_m_tready),
        .o_m_tvalid        (o_m_tvalid),
        .o_first_index     (first_index),
        .o_second_index    (second_index),
        .o_penetration     (penetration),
        .o_normal_on_y     (normal_on_y),
        .o_normal_negative (normal_negative),
        .o_frame_done      (o_m_tlast),
        .o_overflowed      (o_m_tuser)
    );

    // Pack the result fields, lowest first, padded to a whole byte.
    assign o_m_tdata = {1'b0, normal_negative, normal_on_y, penetration,
                        second_index, first_index};

endmodule
